// ----- sv/mas_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and word types of the moving average smoother.
package mas_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = 7;
    localparam int SUM_W      = SAMPLE_W + ADDR_W;

    // The divider retires DIV_STEP quotient bits per cycle.
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W     = DIV_ITER * DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = Q_AW + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_SCATTER_MODE  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ACCUM,
        KIND_EMIT
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_back_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       series_end;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
        logic                       out_last;
    } t_out_word;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        t_kind                      kind;
        logic                       sub;
        logic                       last;
        logic [WIN_W-1:0]           n;
        logic signed [SAMPLE_W-1:0] ox;
        logic signed [SAMPLE_W-1:0] ynew;
        logic signed [SAMPLE_W-1:0] yold;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } t_div_req;

endpackage

// ----- sv/mas_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mas_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of classified samples between the front and the back.
module mas_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mas_pkg::t_entry             i_wdata,
    input  logic                        i_pop,
    output mas_pkg::t_entry             o_rdata,
    output logic                        o_empty,
    output logic [mas_pkg::Q_LVL_W-1:0] o_level
);
    import mas_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wptr;
    logic [Q_AW-1:0]    r_rptr;
    logic [Q_LVL_W-1:0] r_level;
    logic [Q_LVL_W-1:0] n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + Q_LVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - Q_LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

// ----- sv/mas_div.sv -----
`timescale 1ns / 1ps
// Iterative unsigned divider of the window sum magnitude by the window length.
module mas_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mas_pkg::t_div_req         i_req,
    output logic                      o_busy,
    output logic [mas_pkg::DIV_W-1:0] o_quotient
);
    import mas_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [WIN_W-1:0]     r_rem;
    logic [WIN_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     s_quo;
    logic [WIN_W-1:0]     s_rem;
    logic [WIN_W:0]       s_trial;

    // The remainder stays below the divisor, so every trial subtract is narrow.
    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        s_rem   = r_rem;
        s_quo   = r_quo;
        s_trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            s_trial = {s_rem, s_quo[DIV_W-1]};
            s_quo   = {s_quo[DIV_W-2:0], 1'b0};
            if (s_trial >= {1'b0, r_dvs}) begin
                s_trial  = s_trial - {1'b0, r_dvs};
                s_quo[0] = 1'b1;
            end
            s_rem = s_trial[WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_ITER - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= s_quo;
            r_rem <= s_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ----- sv/mas_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the delay lines and classifies each sample.
module mas_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mas_pkg::t_in_word           i_sample,
    input  logic [mas_pkg::WIN_W-1:0]   i_window_length,
    input  logic                        i_scatter_mode,
    input  logic [mas_pkg::Q_LVL_W-1:0] i_q_level,
    output logic                        o_full,
    output logic                        o_q_push,
    output mas_pkg::t_entry             o_q_entry
);
    import mas_pkg::*;

    logic                accept;
    logic                pass;
    logic [WIN_W-1:0]    n;
    logic [WIN_W-1:0]    seen_inc;
    logic [ADDR_W-1:0]   y_raddr;
    logic [ADDR_W-1:0]   x_raddr;
    logic [SAMPLE_W-1:0] y_rdata;
    logic [SAMPLE_W-1:0] x_rdata;
    logic [ADDR_W-1:0]   r_wp;
    logic [ADDR_W-1:0]   n_wp;
    logic [WIN_W-1:0]    r_seen;
    logic [WIN_W-1:0]    n_seen;
    logic                r_pend_valid;
    t_entry              r_pend;
    t_entry              n_pend;

    // A pending sample always finds room in the queue on the next cycle.
    assign o_full = r_pend_valid ? (i_q_level >= Q_LVL_W'(Q_DEPTH - 1))
                                 : (i_q_level >= Q_LVL_W'(Q_DEPTH));
    assign accept = i_push && !o_full;

    assign n        = (i_window_length > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                             : i_window_length;
    assign pass     = (n <= WIN_W'(1)) || i_scatter_mode;
    assign seen_inc = (r_seen < WIN_W'(MAX_WINDOW)) ? r_seen + WIN_W'(1) : r_seen;

    // The y word leaving the window is n samples back, the centre x is n/2 back.
    // With the largest window the leaving word sits at the write address itself.
    assign y_raddr = r_wp - n[ADDR_W-1:0];
    assign x_raddr = r_wp - n[ADDR_W:1];

    mas_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !pass),
        .i_waddr (r_wp),
        .i_wdata (i_sample.y_value),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    mas_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !pass),
        .i_waddr (r_wp),
        .i_wdata (i_sample.x_value),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    always_comb begin
        n_wp   = r_wp;
        n_seen = r_seen;
        n_pend = r_pend;
        if (accept) begin
            n_pend.ox   = i_sample.x_value;
            n_pend.ynew = i_sample.y_value;
            n_pend.yold = '0;
            n_pend.last = i_sample.series_end;
            n_pend.n    = n;
            n_pend.sub  = (r_seen >= n);
            if (pass) begin
                n_pend.kind = KIND_PASS;
                n_seen      = '0;
            end else begin
                n_wp        = r_wp + ADDR_W'(1);
                n_pend.kind = (seen_inc >= n) ? KIND_EMIT : KIND_ACCUM;
                n_seen      = i_sample.series_end ? '0 : seen_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_seen       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_wp         <= n_wp;
            r_seen       <= n_seen;
            r_pend_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // The history words arrive in the cycle after the accept, with the pending sample.
    always_comb begin
        o_q_entry      = r_pend;
        o_q_entry.yold = y_rdata;
        if (r_pend.kind != KIND_PASS) begin
            o_q_entry.ox = x_rdata;
        end
    end

    assign o_q_push = r_pend_valid;

endmodule

// ----- sv/mas_back.sv -----
`timescale 1ns / 1ps
// Back end: running window sum, mean through the divider, and the result register.
module mas_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  mas_pkg::t_entry           i_q_entry,
    output logic                      o_q_pop,
    output mas_pkg::t_div_req         o_div_req,
    input  logic                      i_div_busy,
    input  logic [mas_pkg::DIV_W-1:0] i_div_quotient,
    input  logic                      i_pop,
    output logic                      o_empty,
    output mas_pkg::t_out_word        o_result
);
    import mas_pkg::*;

    t_back_state                r_state;
    t_back_state                n_state;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    y_ext;
    logic signed [SUM_W-1:0]    old_ext;
    logic signed [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]           sum_mag;
    logic                       r_neg;
    logic                       n_neg;
    logic signed [SAMPLE_W-1:0] r_ox;
    logic signed [SAMPLE_W-1:0] n_ox;
    logic                       r_last;
    logic                       n_last;
    logic                       q_big;
    logic [SAMPLE_W-1:0]        mean;
    logic                       out_free;
    logic                       load;
    logic                       r_out_valid;
    t_out_word                  r_out;
    t_out_word                  n_out;

    assign y_ext   = {{ADDR_W{i_q_entry.ynew[SAMPLE_W-1]}}, i_q_entry.ynew};
    assign old_ext = i_q_entry.sub ? {{ADDR_W{i_q_entry.yold[SAMPLE_W-1]}}, i_q_entry.yold}
                                   : '0;
    assign sum_new = r_sum - old_ext + y_ext;
    assign sum_mag = sum_new[SUM_W-1] ? -sum_new : sum_new;

    // Saturate the signed quotient to the sample range.
    assign q_big = |i_div_quotient[DIV_W-1:SAMPLE_W-1];
    always_comb begin
        if (r_neg) begin
            mean = q_big ? {1'b1, {(SAMPLE_W-1){1'b0}}} : -i_div_quotient[SAMPLE_W-1:0];
        end else begin
            mean = q_big ? {1'b0, {(SAMPLE_W-1){1'b1}}} : i_div_quotient[SAMPLE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state            = r_state;
        n_sum              = r_sum;
        n_neg              = r_neg;
        n_ox               = r_ox;
        n_last             = r_last;
        n_out              = r_out;
        load               = 1'b0;
        o_q_pop            = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = DIV_W'(sum_mag);
        o_div_req.divisor  = i_q_entry.n;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_entry.kind)
                        KIND_PASS: begin
                            if (out_free) begin
                                o_q_pop        = 1'b1;
                                n_sum          = '0;
                                load           = 1'b1;
                                n_out.out_x    = i_q_entry.ox;
                                n_out.out_y    = i_q_entry.ynew;
                                n_out.out_last = i_q_entry.last;
                            end
                        end
                        KIND_ACCUM: begin
                            o_q_pop = 1'b1;
                            n_sum   = i_q_entry.last ? '0 : sum_new;
                        end
                        KIND_EMIT: begin
                            o_q_pop         = 1'b1;
                            n_sum           = i_q_entry.last ? '0 : sum_new;
                            o_div_req.start = 1'b1;
                            n_neg           = sum_new[SUM_W-1];
                            n_ox            = i_q_entry.ox;
                            n_last          = i_q_entry.last;
                            n_state         = ST_DIV;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (!i_div_busy && out_free) begin
                    load           = 1'b1;
                    n_out.out_x    = r_ox;
                    n_out.out_y    = mean;
                    n_out.out_last = r_last;
                    n_state        = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_ox   <= n_ox;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ----- sv/moving_average_smoother_top.sv -----
`timescale 1ns / 1ps
// Top level of the moving average smoother: configuration, front, queue, divider, back.
//
// Usage. Samples enter through a queue-like port: a word is taken at a rising edge
// with push high and full low. Results leave the same way: while empty is low the
// oldest result is on o_result, and it is taken at an edge with pop high. The
// configuration channel (window length, scatter mode) is always ready and must be
// written only while the block holds no unfinished sample.
// A taken sample passes the front's pending register and the queue; the back end then
// loads a pass-through result straight into the result register, an averaged one after
// the divider. Throughput. Pass-through samples and samples that give no result are
// taken one per cycle while full stays low. Each averaged result holds the back end
// to start the divider, while it retires four quotient bits per cycle of the sum
// magnitude padded to forty bits, and to load the result register.
// Reset clears the configuration to window one without scatter mode, the window
// sum and sample count, the queue and the result register. The history RAMs are not
// cleared; only words written earlier in the current series are ever read.
// When the receiver stalls the result register holds, the back end stops, the
// four-entry queue fills, and full rises to hold off the source.
module moving_average_smoother_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  mas_pkg::t_in_word              i_sample,
    output logic                           empty,
    input  logic                           pop,
    output mas_pkg::t_out_word             o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mas_pkg::*;

    logic [WIN_W-1:0]   r_window_length;
    logic               r_scatter_mode;
    logic               q_push;
    t_entry             q_wdata;
    t_entry             q_rdata;
    logic               q_pop;
    logic               q_empty;
    logic [Q_LVL_W-1:0] q_level;
    t_div_req           div_req;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quotient;

    // Configuration registers are always ready to take a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WIN_W'(1);
            r_scatter_mode  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                CFG_SCATTER_MODE:  r_scatter_mode  <= i_cfg_data[0];
            endcase
        end
    end

    // The front writes the delay lines and decides for each sample whether it passes
    // through, only feeds the sum, or produces an averaged result.
    mas_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_sample        (i_sample),
        .i_window_length (r_window_length),
        .i_scatter_mode  (r_scatter_mode),
        .i_q_level       (q_level),
        .o_full          (full),
        .o_q_push        (q_push),
        .o_q_entry       (q_wdata)
    );

    // The queue lets the front keep taking samples while the divider is busy.
    mas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    mas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    // The back keeps the running sum in sample order and owns the result register.
    mas_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_entry      (q_rdata),
        .o_q_pop        (q_pop),
        .o_div_req      (div_req),
        .i_div_busy     (div_busy),
        .i_div_quotient (div_quotient),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // The front must never push into a full queue.
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < Q_LVL_W'(Q_DEPTH)))
        else $error("sample queue overflow");

    // While a mean is being computed the back must not consume further samples.
    a_no_pop_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !q_pop)
        else $error("queue popped while the divider is busy");

    // A division starts only for a sample that is being taken from the queue.
    a_div_start_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (q_pop && !q_empty && !div_busy))
        else $error("divider started without a queued sample");
`endif

endmodule
